>>> rtl/core/file_magic_type_classifier_assert.svh
// assertion macros for the file magic type classifier
`ifndef FILE_MAGIC_TYPE_CLASSIFIER_ASSERT_SVH
`define FILE_MAGIC_TYPE_CLASSIFIER_ASSERT_SVH
`ifndef SYNTHESIS
`define FMTC_ASSERT_IMP(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error("fmtc: implication check failed");
`define FMTC_ASSERT_NXT(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error("fmtc: next-cycle check failed");
`else
`define FMTC_ASSERT_IMP(label, clk, rst_n, pre, post)
`define FMTC_ASSERT_NXT(label, clk, rst_n, pre, post)
`endif
`endif

>>> rtl/core/fmtc_pkg.sv
// types, signature tables and constants for the file magic type classifier
`default_nettype none
package fmtc_pkg;

	localparam int NUM_SIGS = 10;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} in_word_t;

	typedef struct packed {
		logic [3:0] file_type;
		logic       tar_by_checksum;
	} out_word_t;

	typedef struct packed {
		logic ustar_hit;
		logic chk_hit;
	} tar_status_t;

	localparam logic [3:0] TYPE_UNKNOWN = 4'd0;
	localparam logic [3:0] TYPE_TAR     = 4'd8;
	localparam logic [3:0] TYPE_MAX     = 4'd10;

	// flag bit of the tar entry, which has no prefix
	localparam int TAR_IDX = 7;

	localparam logic [9:0] POS_SAT   = 10'd513;
	localparam logic [9:0] HDR_LEN   = 10'd512;
	localparam logic [9:0] CHK_OFF   = 10'd148;
	localparam logic [9:0] MAGIC_OFF = 10'd257;
	localparam logic [7:0] SPACE_BYTE = 8'h20;
	localparam logic [7:0] DIGIT_ZERO = 8'h30;

	localparam logic [2:0] SIG_LEN [NUM_SIGS] = '{
		3'd5, 3'd5, 3'd5, 3'd7, 3'd4, 3'd4, 3'd4, 3'd0, 3'd3, 3'd6
	};

	// prefixes, padded to eight bytes
	localparam logic [7:0] SIG_BYTES [NUM_SIGS][8] = '{
		'{8'h7B, 8'h5C, 8'h72, 8'h74, 8'h66, 8'h00, 8'h00, 8'h00},
		'{8'h68, 8'h74, 8'h6D, 8'h6C, 8'h3E, 8'h00, 8'h00, 8'h00},
		'{8'h3C, 8'h3F, 8'h78, 8'h6D, 8'h6C, 8'h00, 8'h00, 8'h00},
		'{8'h25, 8'h50, 8'h44, 8'h46, 8'h2D, 8'h31, 8'h2E, 8'h00},
		'{8'hD0, 8'hCF, 8'h11, 8'hE0, 8'h00, 8'h00, 8'h00, 8'h00},
		'{8'h52, 8'h61, 8'h72, 8'h21, 8'h00, 8'h00, 8'h00, 8'h00},
		'{8'h50, 8'h4B, 8'h03, 8'h04, 8'h00, 8'h00, 8'h00, 8'h00},
		'{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{8'h1F, 8'h8B, 8'h08, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{8'h37, 8'h7A, 8'hBC, 8'hAF, 8'h27, 8'h1C, 8'h00, 8'h00}
	};

	localparam logic [7:0] USTAR_BYTES [8] = '{
		8'h75, 8'h73, 8'h74, 8'h61, 8'h72, 8'h20, 8'h00, 8'h00
	};

endpackage
`default_nettype wire

>>> rtl/core/file_magic_type_classifier.sv
// file magic type classifier: top level
// Usage: the bytes of a file enter on the byte channel (byte_valid, byte_ready,
// byte_word), one word per byte from offset 0, with last_byte set on the
// final byte. For that final byte one word leaves on the type channel
// (type_valid, type_ready, type_word) with the type code and, for tar, whether
// the header checksum decided it. Other bytes give no output word.
// A byte taken from the byte channel is held in the input register and worked
// from there; its result is registered in the output register.
// Throughput, set by the single input register feeding one pass of compare
// and add logic, is one byte per cycle unless a final byte has to wait.
// A final byte waits in the input register while the output register still
// holds an untaken result, and no byte is taken until it moves on; ordinary
// bytes pass a full output register without waiting.
// Reset (arst_n low) empties both registers and starts a new file at offset
// zero; after each final byte the block also starts a new file by itself.
// A stalled receiver holds type_word unchanged until type_ready is seen.
`default_nettype none
`include "file_magic_type_classifier_assert.svh"
module file_magic_type_classifier import fmtc_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      byte_valid,
	output logic      byte_ready,
	input  in_word_t  byte_word,
	output logic      type_valid,
	input  logic      type_ready,
	output out_word_t type_word
);

	logic              valid_s1;
	in_word_t          word_s1;
	logic              type_valid_q;
	out_word_t         type_word_q;
	logic [9:0]        pos_q;
	logic [NUM_SIGS-1:0] flags_q;

	logic              slot_free;
	logic              step;
	logic              finish;
	logic [NUM_SIGS-1:0] flags_next;
	logic [NUM_SIGS-1:0] hit;
	logic [10:0]       count;
	logic              tar_long;
	tar_status_t       tar_status;
	logic [3:0]        type_code;
	logic              by_chk;

	assign slot_free  = !type_valid_q || type_ready;
	assign step       = valid_s1 && (!word_s1.last_byte || slot_free);
	assign finish     = step && word_s1.last_byte;
	assign byte_ready = !valid_s1 || step;
	assign type_valid = type_valid_q;
	assign type_word  = type_word_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (byte_ready) begin
			valid_s1 <= byte_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_valid && byte_ready) begin
			word_s1 <= byte_word;
		end
	end

	fmtc_tar_chk u_tar_chk (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.clear     (word_s1.last_byte),
		.data_byte (word_s1.data_byte),
		.pos       (pos_q),
		.status    (tar_status)
	);

	assign count    = {1'b0, pos_q} + 11'd1;
	assign tar_long = (pos_q >= HDR_LEN);

	always_comb begin
		for (int k = 0; k < NUM_SIGS; k++) begin
			flags_next[k] = flags_q[k];
			if ((pos_q < {7'd0, SIG_LEN[k]})
					&& (word_s1.data_byte != SIG_BYTES[k][pos_q[2:0]])) begin
				flags_next[k] = 1'b0;
			end
			hit[k] = flags_next[k] && (count >= {8'd0, SIG_LEN[k]});
		end
		hit[TAR_IDX] = tar_long && (tar_status.ustar_hit || tar_status.chk_hit);
	end

	// lowest index wins
	always_comb begin
		type_code = TYPE_UNKNOWN;
		for (int k = NUM_SIGS - 1; k >= 0; k--) begin
			if (hit[k]) begin
				type_code = 4'(k + 1);
			end
		end
		by_chk = (type_code == TYPE_TAR) && !tar_status.ustar_hit;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			flags_q <= '1;
		end else if (step) begin
			if (word_s1.last_byte) begin
				pos_q   <= '0;
				flags_q <= '1;
			end else begin
				pos_q   <= (pos_q < POS_SAT) ? pos_q + 10'd1 : POS_SAT;
				flags_q <= flags_next;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			type_valid_q <= 1'b0;
		end else if (finish) begin
			type_valid_q <= 1'b1;
		end else if (type_ready) begin
			type_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			type_word_q.file_type       <= type_code;
			type_word_q.tar_by_checksum <= by_chk;
		end
	end

	`FMTC_ASSERT_IMP(a_pos_sat, clk, arst_n, 1'b1, pos_q <= POS_SAT)
	`FMTC_ASSERT_IMP(a_tar_flag, clk, arst_n, 1'b1, flags_q[TAR_IDX])
	`FMTC_ASSERT_NXT(a_new_file, clk, arst_n, finish, (pos_q == 10'd0) && (flags_q == '1))
	`FMTC_ASSERT_IMP(a_chk_tar, clk, arst_n, type_valid && type_word.tar_by_checksum, type_word.file_type == TYPE_TAR)
	`FMTC_ASSERT_IMP(a_code_range, clk, arst_n, type_valid, type_word.file_type <= TYPE_MAX)
	`FMTC_ASSERT_IMP(a_no_overrun, clk, arst_n, finish && type_valid, type_ready)

endmodule
`default_nettype wire

>>> rtl/core/fmtc_tar_chk.sv
// tar header tracking: ustar magic and header checksum
`default_nettype none
module fmtc_tar_chk import fmtc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        step,
	input  logic        clear,
	input  logic [7:0]  data_byte,
	input  logic [9:0]  pos,
	output tar_status_t status
);

	// weight of each checksum digit as a left shift
	localparam logic [3:0] CHK_SHIFT [8] = '{
		4'd15, 4'd12, 4'd9, 4'd6, 4'd3, 4'd0, 4'd0, 4'd0
	};

	logic [16:0] sum_q;
	logic [22:0] stored_q;
	logic        ustar_q;

	logic [16:0] sum_next;
	logic [22:0] stored_next;
	logic        ustar_next;
	logic [2:0]  magic_idx;
	logic [2:0]  chk_idx;
	logic        in_magic;
	logic        in_chk;
	logic [22:0] digit;

	assign magic_idx = 3'(pos - MAGIC_OFF);
	assign chk_idx   = 3'(pos - CHK_OFF);
	assign in_magic  = (pos >= MAGIC_OFF) && (pos < MAGIC_OFF + 10'd6);
	assign in_chk    = (pos >= CHK_OFF) && (pos < CHK_OFF + 10'd8);
	assign digit     = {15'd0, data_byte - DIGIT_ZERO} << CHK_SHIFT[chk_idx];

	always_comb begin
		ustar_next  = ustar_q;
		sum_next    = sum_q;
		stored_next = stored_q;
		if (in_magic && (data_byte != USTAR_BYTES[magic_idx])) begin
			ustar_next = 1'b0;
		end
		if (pos < HDR_LEN) begin
			if (in_chk) begin
				// checksum field counts as spaces
				sum_next = sum_q + {9'd0, SPACE_BYTE};
				if (data_byte >= DIGIT_ZERO) begin
					stored_next = stored_q + digit;
				end
			end else begin
				sum_next = sum_q + {9'd0, data_byte};
			end
		end
	end

	assign status.ustar_hit = ustar_next;
	assign status.chk_hit   = ({6'd0, sum_next} == stored_next);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q    <= '0;
			stored_q <= '0;
			ustar_q  <= 1'b1;
		end else if (step) begin
			if (clear) begin
				sum_q    <= '0;
				stored_q <= '0;
				ustar_q  <= 1'b1;
			end else begin
				sum_q    <= sum_next;
				stored_q <= stored_next;
				ustar_q  <= ustar_next;
			end
		end
	end

endmodule
`default_nettype wire

>>> dv/file_magic_type_classifier_tb.sv
// self-checking testbench for the file magic type classifier
`timescale 1ns / 1ps
module file_magic_type_classifier_tb;
	import fmtc_pkg::*;

	typedef enum logic [3:0] {
		FT_UNKNOWN = 4'd0,
		FT_RTF     = 4'd1,
		FT_HTML    = 4'd2,
		FT_XML     = 4'd3,
		FT_PDF     = 4'd4,
		FT_OLE     = 4'd5,
		FT_RAR     = 4'd6,
		FT_ZIP     = 4'd7,
		FT_TAR     = 4'd8,
		FT_GZIP    = 4'd9,
		FT_7Z      = 4'd10
	} file_type_e;

	typedef enum int {
		TAR_NOISE,
		TAR_MAGIC,
		TAR_CHECKSUM,
		TAR_BOTH,
		TAR_SPLIT
	} tar_header_e;

	localparam int MAGIC_COUNT = 10;
	// indexed by type code - 1; the tar row has no prefix
	localparam int MAGIC_LEN [MAGIC_COUNT] = '{5, 5, 5, 7, 4, 4, 4, 0, 3, 6};
	localparam logic [7:0] MAGIC_BYTES [MAGIC_COUNT][7] = '{
		'{8'h7B, 8'h5C, 8'h72, 8'h74, 8'h66, 8'h00, 8'h00},
		'{8'h68, 8'h74, 8'h6D, 8'h6C, 8'h3E, 8'h00, 8'h00},
		'{8'h3C, 8'h3F, 8'h78, 8'h6D, 8'h6C, 8'h00, 8'h00},
		'{8'h25, 8'h50, 8'h44, 8'h46, 8'h2D, 8'h31, 8'h2E},
		'{8'hD0, 8'hCF, 8'h11, 8'hE0, 8'h00, 8'h00, 8'h00},
		'{8'h52, 8'h61, 8'h72, 8'h21, 8'h00, 8'h00, 8'h00},
		'{8'h50, 8'h4B, 8'h03, 8'h04, 8'h00, 8'h00, 8'h00},
		'{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{8'h1F, 8'h8B, 8'h08, 8'h00, 8'h00, 8'h00, 8'h00},
		'{8'h37, 8'h7A, 8'hBC, 8'hAF, 8'h27, 8'h1C, 8'h00}
	};
	localparam logic [7:0] USTAR_MAGIC [6] = '{8'h75, 8'h73, 8'h74, 8'h61, 8'h72, 8'h20};

	localparam logic [9:0] POSITION_MAX = 10'd513;
	localparam int HEADER_BYTES = 512;
	localparam int FIELD_START  = 148;
	localparam int USTAR_START  = 257;
	localparam logic [7:0] SPACE_CHAR = 8'h20;
	localparam logic [7:0] ZERO_CHAR  = 8'h30;

	localparam int HOLD_CYCLES    = 300;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int DRAIN_CYCLES   = 8;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      byte_valid = 1'b0;
	logic      byte_ready;
	in_word_t  byte_word = '0;
	logic      type_valid;
	logic      type_ready = 1'b0;
	out_word_t type_word;

	// classifier state tracked alongside the block
	logic [9:0]  cur_pos;
	logic [9:0]  prefix_ok;
	logic [16:0] header_sum;
	logic [22:0] field_value;
	logic        ustar_ok;

	out_word_t   pending_types [$];
	logic [7:0]  file_bytes [$];

	int send_idle_pct = 0;
	int stall_pct = 0;
	int hold_reqs = 0;
	int hold_seen = 0;
	int hold_left = 0;
	int quiet_cycles = 0;
	int fail_count = 0;
	int files_sent = 0;
	int bytes_sent = 0;
	int types_checked = 0;
	int tar_by_sum_seen = 0;
	int input_stall_cycles = 0;
	logic [15:0] types_seen = '0;

	file_magic_type_classifier dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_ready (byte_ready),
		.byte_word  (byte_word),
		.type_valid (type_valid),
		.type_ready (type_ready),
		.type_word  (type_word)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic void restart_file();
		cur_pos = '0;
		prefix_ok = '1;
		header_sum = '0;
		field_value = '0;
		ustar_ok = 1'b1;
	endfunction

	// returns 1 when the byte ends a file, with its type word in res
	function automatic logic classify_byte(input logic [7:0] b, input logic last,
			output out_word_t res);
		logic [9:0] pos;
		logic [22:0] weighted;
		logic found;
		int k;
		int idx;
		pos = cur_pos;
		res = '0;
		for (k = 0; k < MAGIC_COUNT; k++) begin
			if (pos < MAGIC_LEN[k]) begin
				if (b != MAGIC_BYTES[k][pos])
					prefix_ok[k] = 1'b0;
			end
		end
		if (pos >= USTAR_START && pos < USTAR_START + 6) begin
			if (b != USTAR_MAGIC[pos - USTAR_START])
				ustar_ok = 1'b0;
		end
		if (pos < HEADER_BYTES) begin
			if (pos >= FIELD_START && pos < FIELD_START + 8) begin
				idx = pos - FIELD_START;
				// checksum field counts as spaces in the sum
				header_sum = header_sum + SPACE_CHAR;
				if (b >= ZERO_CHAR) begin
					weighted = 23'(b - ZERO_CHAR);
					if (idx < 5)
						weighted = weighted << (3 * (5 - idx));
					field_value = field_value + weighted;
				end
			end else begin
				header_sum = header_sum + b;
			end
		end
		if (pos < POSITION_MAX)
			cur_pos = pos + 10'd1;
		if (!last)
			return 1'b0;
		found = 1'b0;
		for (k = 0; k < MAGIC_COUNT; k++) begin
			if (!found) begin
				if (k + 1 == FT_TAR) begin
					if (pos >= HEADER_BYTES) begin
						if (ustar_ok) begin
							found = 1'b1;
							res.file_type = FT_TAR;
						end else if ({6'd0, header_sum} == field_value) begin
							found = 1'b1;
							res.file_type = FT_TAR;
							res.tar_by_checksum = 1'b1;
						end
					end
				end else if (prefix_ok[k] && int'(pos) + 1 >= MAGIC_LEN[k]) begin
					found = 1'b1;
					res.file_type = 4'(k + 1);
				end
			end
		end
		restart_file();
		return 1'b1;
	endfunction

	task automatic send_byte(input logic [7:0] b, input logic last);
		in_word_t w;
		out_word_t res;
		while ($urandom_range(99) < send_idle_pct) begin
			byte_valid <= 1'b0;
			@(posedge clk);
		end
		w.data_byte = b;
		w.last_byte = last;
		byte_valid <= 1'b1;
		byte_word <= w;
		@(posedge clk);
		while (!byte_ready)
			@(posedge clk);
		if (classify_byte(b, last, res))
			pending_types.push_back(res);
		bytes_sent++;
	endtask

	task automatic send_file();
		int i;
		for (i = 0; i < file_bytes.size(); i++)
			send_byte(file_bytes[i], i == file_bytes.size() - 1);
		files_sent++;
	endtask

	task automatic wait_drained();
		byte_valid <= 1'b0;
		while (pending_types.size() != 0)
			@(posedge clk);
	endtask

	task automatic add_bytes(input logic [7:0] b0, input int n, input int kind);
		int i;
		file_bytes.delete();
		if (kind >= 0) begin
			for (i = 0; i < n; i++)
				file_bytes.push_back(MAGIC_BYTES[kind][i]);
		end else begin
			file_bytes.push_back(b0);
		end
	endtask

	// a signature prefix that is whole, cut short or spoilt, then a random tail
	task automatic build_signature_file(input int kind);
		int n;
		add_bytes(8'h00, MAGIC_LEN[kind], kind);
		n = MAGIC_LEN[kind];
		case ($urandom_range(3))
			0: begin
				repeat ($urandom_range(1, n - 1))
					void'(file_bytes.pop_back());
			end
			1: begin
				file_bytes[$urandom_range(n - 1)] = 8'($urandom_range(255));
			end
			default: ;
		endcase
		repeat ($urandom_range(6))
			file_bytes.push_back(8'($urandom_range(255)));
	endtask

	task automatic build_tar_file(input tar_header_e mode, input int len, input int kind);
		int i;
		int lo;
		int hi;
		logic [16:0] hsum;
		logic [16:0] val;
		file_bytes.delete();
		for (i = 0; i < len; i++)
			file_bytes.push_back(8'($urandom_range(255)));
		if (kind >= 0) begin
			for (i = 0; i < MAGIC_LEN[kind]; i++)
				file_bytes[i] = MAGIC_BYTES[kind][i];
		end
		if (mode == TAR_MAGIC || mode == TAR_BOTH) begin
			for (i = 0; i < 6; i++)
				file_bytes[USTAR_START + i] = USTAR_MAGIC[i];
		end
		if (mode == TAR_CHECKSUM || mode == TAR_BOTH || mode == TAR_SPLIT) begin
			hsum = '0;
			for (i = 0; i < HEADER_BYTES; i++)
				hsum = hsum + ((i >= FIELD_START && i < FIELD_START + 8) ?
					SPACE_CHAR : file_bytes[i]);
			lo = 0;
			hi = 0;
			// split form: the two unit-weight trailing digits carry part of the value
			if (mode == TAR_SPLIT) begin
				lo = $urandom_range(7);
				hi = $urandom_range(7);
			end
			val = hsum - 17'(lo) - 17'(hi);
			for (i = 0; i < 6; i++)
				file_bytes[FIELD_START + i] = ZERO_CHAR + 8'((val >> (3 * (5 - i))) & 17'd7);
			file_bytes[FIELD_START + 6] = (mode == TAR_SPLIT) ? ZERO_CHAR + 8'(lo) : 8'h00;
			file_bytes[FIELD_START + 7] = (mode == TAR_SPLIT) ? ZERO_CHAR + 8'(hi) : SPACE_CHAR;
		end
	endtask

	function automatic int random_kind();
		int kind;
		kind = $urandom_range(8);
		if (kind + 1 >= FT_TAR)
			kind++;
		return kind;
	endfunction

	// receiver: random stalls, plus a long hold-off on request
	always @(posedge clk) begin
		if (hold_reqs != hold_seen) begin
			hold_seen <= hold_reqs;
			hold_left <= HOLD_CYCLES;
			type_ready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			type_ready <= 1'b0;
		end else begin
			type_ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	always @(posedge clk) begin : type_check
		out_word_t want;
		if (arst_n && type_valid && type_ready) begin
			if (pending_types.size() == 0) begin
				$error("type word %0d/%0d with none expected",
					type_word.file_type, type_word.tar_by_checksum);
				fail_count++;
			end else begin
				want = pending_types.pop_front();
				types_checked++;
				types_seen[want.file_type] = 1'b1;
				if (want.tar_by_checksum)
					tar_by_sum_seen++;
				if (type_word.file_type !== want.file_type) begin
					$error("file_type: expected %0d, got %0d",
						want.file_type, type_word.file_type);
					fail_count++;
				end
				if (type_word.tar_by_checksum !== want.tar_by_checksum) begin
					$error("tar_by_checksum: expected %0d, got %0d",
						want.tar_by_checksum, type_word.tar_by_checksum);
					fail_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (byte_valid && !byte_ready)
			input_stall_cycles++;
		if (!arst_n || (byte_valid && byte_ready) || (type_valid && type_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no word moved for %0d cycles", WATCHDOG_LIMIT);
			$display("** file_magic_type_classifier: FAILED **");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// short files: lowest and highest single bytes, whole, cut and spoilt prefixes
	task automatic test_short_files();
		add_bytes(8'h00, 1, -1);
		send_file();
		add_bytes(8'hFF, 1, -1);
		send_file();
		add_bytes(8'h00, 4, FT_RTF - 1);
		send_file();
		add_bytes(8'h00, 3, FT_GZIP - 1);
		send_file();
		add_bytes(8'h00, 3, FT_GZIP - 1);
		file_bytes[2] = 8'h00;
		send_file();
		add_bytes(8'h00, 6, FT_7Z - 1);
		send_file();
		add_bytes(8'h00, 4, FT_OLE - 1);
		send_file();
		wait_drained();
	endtask

	task automatic test_each_signature();
		int k;
		for (k = 0; k < MAGIC_COUNT; k++) begin
			if (k + 1 != FT_TAR) begin
				add_bytes(8'h00, MAGIC_LEN[k], k);
				repeat ($urandom_range(3))
					file_bytes.push_back(8'($urandom_range(255)));
				send_file();
			end
		end
		wait_drained();
	endtask

	task automatic test_tar_headers();
		build_tar_file(TAR_MAGIC, 513, -1);
		send_file();
		build_tar_file(TAR_CHECKSUM, 520, -1);
		send_file();
		build_tar_file(TAR_BOTH, 600, -1);
		send_file();
		build_tar_file(TAR_SPLIT, 530, -1);
		send_file();
		build_tar_file(TAR_NOISE, 515, -1);
		send_file();
		// one byte too short for tar either way
		build_tar_file(TAR_MAGIC, 512, -1);
		send_file();
		build_tar_file(TAR_CHECKSUM, 512, -1);
		send_file();
		// rtf outranks tar, tar outranks gzip
		build_tar_file(TAR_MAGIC, 520, FT_RTF - 1);
		send_file();
		build_tar_file(TAR_CHECKSUM, 520, FT_GZIP - 1);
		send_file();
		wait_drained();
	endtask

	task automatic test_receiver_hold();
		int i;
		send_idle_pct = 0;
		stall_pct = 0;
		hold_reqs++;
		for (i = 0; i < 12; i++) begin
			build_signature_file(random_kind());
			send_file();
		end
		wait_drained();
	endtask

	task automatic test_random_files(input int idle, input int stall, input int budget,
			input int tar_files);
		int start;
		int kind;
		send_idle_pct = idle;
		stall_pct = stall;
		start = bytes_sent;
		while (bytes_sent - start < budget) begin
			if ($urandom_range(99) < 70) begin
				build_signature_file(random_kind());
			end else begin
				file_bytes.delete();
				repeat ($urandom_range(1, 12))
					file_bytes.push_back(8'($urandom_range(255)));
			end
			send_file();
		end
		repeat (tar_files) begin
			kind = ($urandom_range(3) == 0) ? random_kind() : -1;
			build_tar_file(tar_header_e'($urandom_range(4)), $urandom_range(512, 540), kind);
			send_file();
		end
		wait_drained();
	endtask

	initial begin
		restart_file();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_short_files();
		test_each_signature();
		test_tar_headers();
		test_receiver_hold();
		test_random_files(0, 0, 100, 1);
		test_random_files(86, 0, 100, 1);
		test_random_files(0, 86, 100, 1);
		test_random_files(37, 37, 100, 1);

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (pending_types.size() != 0) begin
			$error("%0d type words never arrived", pending_types.size());
			fail_count++;
		end
		$display("run: %0d files, %0d bytes, %0d type words checked, %0d tar by checksum",
			files_sent, bytes_sent, types_checked, tar_by_sum_seen);
		$display("type codes seen (mask) 0x%0h, input stalled for %0d cycles",
			types_seen, input_stall_cycles);
		if (fail_count == 0)
			$display("** file_magic_type_classifier: PASSED **");
		else
			$display("** file_magic_type_classifier: FAILED **");
		$finish;
	end

endmodule

>>> file_magic_type_classifier.f
+incdir+rtl/core
rtl/core/fmtc_pkg.sv
rtl/core/fmtc_tar_chk.sv
rtl/core/file_magic_type_classifier.sv
dv/file_magic_type_classifier_tb.sv
